// ===== hdl/bfns_pkg.sv =====
`timescale 1ns / 1ps
package bfns_pkg;

   // bitmap geometry
   localparam int BITMAP_BITS = 1024;
   localparam int WORD_BITS   = 64;
   localparam int BIT_POS_W   = $clog2(WORD_BITS);
   localparam int WORD_COUNT  = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int TAIL_BITS   = BITMAP_BITS % WORD_BITS;

   // field widths
   localparam int CMD_W   = 4;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;
   localparam int ADDR_W  = INDEX_W - BIT_POS_W;

   localparam logic [ADDR_W-1:0]  LAST_WORD = ADDR_W'(WORD_COUNT - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BITMAP_BITS);

   // command codes
   localparam logic [CMD_W-1:0] CMD_SET        = 4'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd1;
   localparam logic [CMD_W-1:0] CMD_FLIP       = 4'd2;
   localparam logic [CMD_W-1:0] CMD_TEST       = 4'd3;
   localparam logic [CMD_W-1:0] CMD_SET_ALL    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR_ALL  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_INVERT     = 4'd6;
   localparam logic [CMD_W-1:0] CMD_FIND_NEXT  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_FIND_FIRST = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // what the word unit needs to know about the command in flight
   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [BIT_POS_W-1:0] bit_pos;
      logic                 in_range;
      logic [ADDR_W:0]      start_word;
      logic [BIT_POS_W-1:0] start_bit;
   } word_op_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] new_word;
      logic                 wr_en;
      logic                 old_bit;
      logic                 new_bit;
      logic                 hit;
      logic [BIT_POS_W-1:0] hit_pos;
   } word_res_type;

   // bits beyond the bitmap size in the last word stay clear
   function automatic logic [WORD_BITS-1:0] word_mask(input logic [ADDR_W-1:0] addr);
      logic [WORD_BITS-1:0] m;
      m = '1;
      if (addr == LAST_WORD && TAIL_BITS != 0) begin
         m = (WORD_BITS'(1) << TAIL_BITS) - WORD_BITS'(1);
      end
      return m;
   endfunction

   // binary search for the lowest set bit, one halving per step
   function automatic logic [BIT_POS_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0] t;
      logic [BIT_POS_W-1:0] pos;
      t   = v;
      pos = '0;
      for (int k = BIT_POS_W - 1; k >= 0; k--) begin
         if ((t & ((WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1))) == '0) begin
            pos[k] = 1'b1;
            t      = t >> (1 << k);
         end
      end
      return pos;
   endfunction

endpackage

// ===== hdl/bfns_if.sv =====
`timescale 1ns / 1ps
interface bfns_req_if;
   logic                        valid;
   logic                        ready;
   logic [bfns_pkg::CMD_W-1:0]   cmd;
   logic [bfns_pkg::INDEX_W-1:0] bit_index;

   modport source (output valid, cmd, bit_index, input ready);
   modport sink (input valid, cmd, bit_index, output ready);
endinterface

interface bfns_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         bit_value;
   logic [bfns_pkg::COUNT_W-1:0] found_index;
   logic [bfns_pkg::COUNT_W-1:0] pop_count;
   logic                         any_set;
   logic                         all_set;

   modport source (output valid, bit_value, found_index, pop_count, any_set, all_set,
                   input ready);
   modport sink (input valid, bit_value, found_index, pop_count, any_set, all_set,
                 output ready);
endinterface

// ===== hdl/bfns_ram.sv =====
`timescale 1ns / 1ps
module bfns_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/bfns_word_unit.sv =====
`timescale 1ns / 1ps
module bfns_word_unit (
   input  bfns_pkg::word_op_type                op,
   input  logic [bfns_pkg::ADDR_W-1:0]          addr,
   input  logic [bfns_pkg::WORD_BITS-1:0]       old_word,
   output bfns_pkg::word_res_type               res
);
   import bfns_pkg::*;

   logic [WORD_BITS-1:0] bit_sel;
   logic [WORD_BITS-1:0] new_word;
   logic                 wr_en;
   logic [WORD_BITS-1:0] search;
   logic [ADDR_W:0]      addr_x;
   logic                 is_find;

   assign bit_sel = WORD_BITS'(1) << op.bit_pos;
   assign addr_x  = {1'b0, addr};
   assign is_find = (op.cmd == CMD_FIND_NEXT) || (op.cmd == CMD_FIND_FIRST);

   always_comb begin
      new_word = old_word;
      wr_en    = 1'b0;
      unique case (op.cmd)
         CMD_SET: begin
            new_word = old_word | bit_sel;
            wr_en    = op.in_range;
         end
         CMD_CLEAR: begin
            new_word = old_word & ~bit_sel;
            wr_en    = op.in_range;
         end
         CMD_FLIP: begin
            new_word = old_word ^ bit_sel;
            wr_en    = op.in_range;
         end
         CMD_SET_ALL: begin
            new_word = word_mask(addr);
            wr_en    = 1'b1;
         end
         CMD_CLEAR_ALL: begin
            new_word = '0;
            wr_en    = 1'b1;
         end
         CMD_INVERT: begin
            new_word = ~old_word & word_mask(addr);
            wr_en    = 1'b1;
         end
         default: begin
            new_word = old_word;
            wr_en    = 1'b0;
         end
      endcase
   end

   // words before the start word are skipped, the start word is cut below the start bit
   always_comb begin
      search = '0;
      if (is_find) begin
         priority if (addr_x < op.start_word) begin
            search = '0;
         end else if (addr_x == op.start_word) begin
            search = old_word & ({WORD_BITS{1'b1}} << op.start_bit);
         end else begin
            search = old_word;
         end
      end
   end

   always_comb begin
      res.new_word = wr_en ? new_word : old_word;
      res.wr_en    = wr_en;
      res.old_bit  = old_word[op.bit_pos];
      res.new_bit  = res.new_word[op.bit_pos];
      res.hit      = |search;
      res.hit_pos  = lowest_set(search);
   end
endmodule

// ===== hdl/bitmap_find_next_set.sv =====
`timescale 1ns / 1ps
// bitmap engine over BITMAP_BITS bits kept as 64-bit words in one synchronous ram
//
// req_bus carries one command word (cmd, bit_index); rsp_bus returns one result
// word per command: bit value after the command, find result, population count,
// any-set and all-set flags. both channels move a word when valid and ready are high
//
// a command walks the ram one word per cycle: read a word, then modify the registered
// word and write it back while the next word is read. single-bit, test and unknown commands
// touch one word; set all, clear all, invert and both finds walk all WORD_COUNT words
// after the walk a drain state ends the last write and a done state loads the response;
// one command is in flight at a time, so a new command is taken only once the last is done
//
// reset clears the per-word valid bits, so every word reads as zero until written;
// there is no clearing pass and the block takes commands right after reset
// a stalled rsp holds its word; the block finishes the next command meanwhile and
// waits with it until the held result is taken
module bitmap_find_next_set (
   input logic clock,
   input logic reset,
   bfns_req_if.sink   req_bus,
   bfns_rsp_if.source rsp_bus
);
   import bfns_pkg::*;

   state_type state_ff, state_in;

   // command latched at accept
   logic [CMD_W-1:0]   cmd_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  last_ff;

   // data stage: word read in the previous cycle
   logic              p_valid_ff, p_valid_in;
   logic [ADDR_W-1:0] p_addr_ff;
   logic              p_known_ff;

   // per-word written flags, cleared by reset
   logic [WORD_COUNT-1:0] known_ff;

   // running results
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] found_ff;
   logic               hit_ff;
   logic               bit_ff;

   // response register
   logic               rsp_valid_ff;
   logic               rsp_bit_ff;
   logic [COUNT_W-1:0] rsp_found_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic                 req_fire;
   logic                 rd_en;
   logic                 rsp_load;
   logic                 walk_cmd;
   logic                 find_cmd;
   logic [ADDR_W-1:0]    req_word;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] old_word;
   logic                 in_range;
   logic [COUNT_W-1:0]   start;
   word_op_type          op;
   word_res_type         res;
   logic                 ram_wr;

   // ---------------- request side ----------------
   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_word = req_bus.bit_index[INDEX_W-1:BIT_POS_W];
   assign walk_cmd = (req_bus.cmd == CMD_SET_ALL) || (req_bus.cmd == CMD_CLEAR_ALL) ||
                     (req_bus.cmd == CMD_INVERT) || (req_bus.cmd == CMD_FIND_NEXT) ||
                     (req_bus.cmd == CMD_FIND_FIRST);
   assign find_cmd = (req_bus.cmd == CMD_FIND_NEXT) || (req_bus.cmd == CMD_FIND_FIRST);

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_fire) state_in = ST_RUN;
         ST_RUN:   if (addr_ff == last_ff) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      p_valid_in    = 1'b0;
      rsp_load      = 1'b0;
      addr_in       = addr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
         end
         ST_RUN: begin
            rd_en      = 1'b1;
            p_valid_in = 1'b1;
            addr_in    = addr_ff + ADDR_W'(1);
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_bus.ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         p_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= req_bus.cmd;
         idx_ff  <= req_bus.bit_index;
         addr_ff <= walk_cmd ? '0 : req_word;
         last_ff <= walk_cmd ? LAST_WORD : req_word;
      end else begin
         addr_ff <= addr_in;
      end
      if (rd_en) begin
         p_addr_ff  <= addr_ff;
         p_known_ff <= known_ff[addr_ff];
      end
   end

   // ---------------- word store ----------------
   bfns_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORD_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (p_addr_ff),
      .wr_data (res.new_word),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // a word never written reads as zero
   assign old_word = p_known_ff ? rd_data : '0;
   assign in_range = {1'b0, idx_ff} < FULL_COUNT;
   // find next starts one past the index; find first starts at zero
   assign start    = (cmd_ff == CMD_FIND_NEXT) ? (COUNT_W'(idx_ff) + COUNT_W'(1)) : '0;

   always_comb begin
      op.cmd        = cmd_ff;
      op.bit_pos    = idx_ff[BIT_POS_W-1:0];
      op.in_range   = in_range;
      op.start_word = start[COUNT_W-1:BIT_POS_W];
      op.start_bit  = start[BIT_POS_W-1:0];
   end

   bfns_word_unit u_word (
      .op       (op),
      .addr     (p_addr_ff),
      .old_word (old_word),
      .res      (res)
   );

   assign ram_wr = p_valid_ff && res.wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff <= '0;
      end else if (ram_wr) begin
         known_ff[p_addr_ff] <= 1'b1;
      end
   end

   // ---------------- running results ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (p_valid_ff) begin
         priority if (cmd_ff == CMD_SET_ALL) begin
            if (p_addr_ff == last_ff) count_ff <= FULL_COUNT;
         end else if (cmd_ff == CMD_CLEAR_ALL) begin
            if (p_addr_ff == last_ff) count_ff <= '0;
         end else if (cmd_ff == CMD_INVERT) begin
            if (p_addr_ff == last_ff) count_ff <= FULL_COUNT - count_ff;
         end else if (res.wr_en) begin
            // single-bit commands: one word only
            count_ff <= count_ff + COUNT_W'(res.new_bit) - COUNT_W'(res.old_bit);
         end else begin
            count_ff <= count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         found_ff <= find_cmd ? FULL_COUNT : '0;
         hit_ff   <= 1'b0;
         bit_ff   <= 1'b0;
      end else if (p_valid_ff) begin
         if (res.hit && !hit_ff) begin
            hit_ff   <= 1'b1;
            found_ff <= COUNT_W'({p_addr_ff, res.hit_pos});
         end
         if (p_addr_ff == idx_ff[INDEX_W-1:BIT_POS_W]) begin
            bit_ff <= res.new_bit && in_range;
         end
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_bit_ff   <= bit_ff;
         rsp_found_ff <= found_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.bit_value   = rsp_bit_ff;
   assign rsp_bus.found_index = rsp_found_ff;
   assign rsp_bus.pop_count   = rsp_count_ff;
   assign rsp_bus.any_set     = rsp_count_ff != '0;
   assign rsp_bus.all_set     = rsp_count_ff == FULL_COUNT;
endmodule
